// ===== rtl/tpt_pkg.sv =====
// types, command codes and queue constants shared by the task priority table
package tpt_pkg;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_EDIT   = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_EXEC   = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] user_id;
      logic [7:0]  task_id;
      logic [29:0] priority_req;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] owner;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_EDIT,
      OP_REMOVE,
      OP_EXEC,
      OP_DROP
   } op_type;

   typedef struct packed {
      op_type  op;
      req_type beat;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/tpt_front.sv =====
// front end: classifies request beats and holds them in a short queue
module tpt_front #(
   parameter int TASK_SLOTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tpt_pkg::req_type    req_beat,
   output logic                q_valid,
   output tpt_pkg::entry_type  q_entry,
   input  logic                q_pop
);
   import tpt_pkg::*;

   entry_type            ent_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 in_range;
   op_type               op;
   logic                 push;
   logic                 pull;

   // classify
   always_comb begin
      in_range = (32'(req_beat.task_id) < 32'(TASK_SLOTS));
      case (req_beat.cmd)
         CMD_ADD:    op = in_range ? OP_ADD : OP_DROP;
         CMD_EDIT:   op = in_range ? OP_EDIT : OP_DROP;
         CMD_REMOVE: op = in_range ? OP_REMOVE : OP_DROP;
         CMD_EXEC:   op = OP_EXEC;
         default:    op = OP_DROP;
      endcase
   end

   assign req_ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_entry   = ent_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pull      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pull) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pull) begin
         count_in = count_ff + 1'b1;
      end else if (pull && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= '{op: op, beat: req_beat};
      end
   end

endmodule

// ===== rtl/tpt_back.sv =====
// back end: slot stores, valid bits, max scan sequencer and result register
module tpt_back #(
   parameter int TASK_SLOTS    = 256,
   parameter int PRIORITY_BITS = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  tpt_pkg::entry_type  q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tpt_pkg::rsp_type    rsp_beat
);
   import tpt_pkg::*;

   localparam int SLOT_BITS = $clog2(TASK_SLOTS);

   state_type                state_ff, state_in;
   logic [SLOT_BITS-1:0]     scan_ff, scan_in;
   logic [TASK_SLOTS-1:0]    valid_ff, valid_in;

   logic [PRIORITY_BITS-1:0] prio_mem [TASK_SLOTS];
   logic [15:0]              user_mem [TASK_SLOTS];
   logic [PRIORITY_BITS-1:0] prio_rd_ff;
   logic [15:0]              user_rd_ff;

   logic                     cand_live_ff;
   logic                     cand_valid_ff;
   logic [SLOT_BITS-1:0]     cand_idx_ff;
   logic                     any_ff;
   logic [PRIORITY_BITS-1:0] best_p_ff;
   logic [SLOT_BITS-1:0]     best_idx_ff;

   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic [SLOT_BITS-1:0]     slot;
   logic [PRIORITY_BITS-1:0] prio;
   logic                     prio_we;
   logic                     user_we;
   logic                     scan_start;
   logic                     rsp_load;

   assign slot = SLOT_BITS'(q_entry.beat.task_id);
   assign prio = PRIORITY_BITS'(q_entry.beat.priority_req);

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      valid_in   = valid_ff;
      prio_we    = 1'b0;
      user_we    = 1'b0;
      q_pop      = 1'b0;
      scan_start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_entry.op)
                  OP_ADD: begin
                     prio_we        = 1'b1;
                     user_we        = 1'b1;
                     valid_in[slot] = 1'b1;
                  end
                  OP_EDIT: begin
                     prio_we = valid_ff[slot];
                  end
                  OP_REMOVE: begin
                     valid_in[slot] = 1'b0;
                  end
                  OP_EXEC: begin
                     scan_start = 1'b1;
                     scan_in    = '0;
                     state_in   = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_ff == SLOT_BITS'(TASK_SLOTS-1)) begin
               scan_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_FETCH;
         ST_FETCH: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               if (any_ff) begin
                  valid_in[best_idx_ff] = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         valid_ff     <= '0;
         cand_live_ff <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         valid_ff     <= valid_in;
         cand_live_ff <= (state_ff == ST_SCAN);
         if (scan_start) begin
            any_ff <= 1'b0;
         end else if (cand_live_ff && cand_valid_ff && (!any_ff || prio_rd_ff >= best_p_ff)) begin
            any_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // running best, later equal priority wins so the highest id is kept
   always_ff @(posedge clock) begin
      cand_valid_ff <= valid_ff[scan_ff];
      cand_idx_ff   <= scan_ff;
      if (cand_live_ff && cand_valid_ff && (!any_ff || prio_rd_ff >= best_p_ff)) begin
         best_p_ff   <= prio_rd_ff;
         best_idx_ff <= cand_idx_ff;
      end
      if (rsp_load) begin
         rsp_ff.found <= any_ff;
         rsp_ff.owner <= any_ff ? user_rd_ff : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (prio_we) begin
         prio_mem[slot] <= prio;
      end
      prio_rd_ff <= prio_mem[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (user_we) begin
         user_mem[slot] <= q_entry.beat.user_id;
      end
      user_rd_ff <= user_mem[best_idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

// ===== rtl/task_priority_table.sv =====
// top level of the indexed max-priority task table
//
//   channel  direction  beat type   moves
//   req      in         req_type    cmd, user_id, task_id, priority_req
//   rsp      out        rsp_type    found, owner (execute top only)
//
// add, edit, remove and dropped commands are applied by the back end in its idle state
// execute top scans one slot a cycle through the priority memory port
// reset clears the slot valid bits at once, no clearing pass
// a two-beat queue lets req be taken while a scan runs or a result waits on rsp
module task_priority_table #(
   parameter int TASK_SLOTS    = 256,
   parameter int PRIORITY_BITS = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tpt_pkg::req_type  req_beat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tpt_pkg::rsp_type  rsp_beat
);
   import tpt_pkg::*;

   logic      q_valid;
   logic      q_pop;
   entry_type q_entry;

   tpt_front #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop)
   );

   tpt_back #(
      .TASK_SLOTS    (TASK_SLOTS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

endmodule

// ===== rtl/tpt_checker.sv =====
// port-level checks on the task priority table, bound to the top level
module tpt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tpt_pkg::rsp_type rsp_beat
);

   // result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))
      else $error("rsp beat dropped or changed while stalled");

   // empty result carries no owner
   a_not_found_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_beat.found |-> rsp_beat.owner == 16'd0)
      else $error("owner set on not-found result");

   // reset leaves no result pending
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // reset empties the queue
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready after reset");

endmodule

bind task_priority_table tpt_checker u_chk (.*);
